// File: src/ttb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_pkg
// Types and constants shared by the timeout timer bank modules.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ARM    = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    // most expiries reported on one tick
    localparam logic [4:0] MAX_FIRE = 5'd16;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  slot;
        logic [31:0] delay_ms;
        logic [15:0] action_tag;
        logic [15:0] context_tag;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  fired_slot;
        logic [15:0] fired_action;
        logic [15:0] fired_context;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [63:0] deadline;
        logic [15:0] action_tag;
        logic [15:0] ctx_tag;
    } slot_entry_t;

endpackage

// File: src/ttb_add64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_add64
// Shared 64-bit adder: deadline sum, time increment and deadline compare.
// ----------------------------------------------------------------------------
module ttb_add64 (
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    input  logic        sub,
    output logic [63:0] sum,
    output logic        carry
);

    logic [64:0] full;

    // subtract as a + ~b + 1; carry out set means a >= b
    assign full  = {1'b0, op_a} + {1'b0, op_b ^ {64{sub}}} + 65'(sub);
    assign sum   = full[63:0];
    assign carry = full[64];

endmodule

// File: src/ttb_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_slot_ram
// Slot storage: deadline and tags, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttb_slot_ram #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  ttb_pkg::slot_entry_t wr_data,
    input  logic [IDX_W-1:0]    rd_addr,
    output ttb_pkg::slot_entry_t rd_data
);
    import ttb_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/timeout_timer_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timeout_timer_bank
// Bank of one-shot millisecond timers with an iterative expiry scan.
// ----------------------------------------------------------------------------
// Arm, cancel and unused op items are taken straight from the idle state.
// A tick item goes through S_TICK to advance the time, then S_SCAN, one
// slot at a time through the shared 64-bit adder used as the deadline
// compare, then S_FLUSH to release the last result; a stalled result output
// holds the scan or the flush. Reset clears time, armed flags and control;
// slot memory is not cleared and its contents are used only for armed slots.
module timeout_timer_bank #(
    parameter int NUM_SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ttb_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ttb_pkg::out_item_t m_item
);
    import ttb_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TICK  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [63:0]            now_reg, now_next;
    logic [NUM_SLOTS-1:0]   armed_reg, armed_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [4:0]             fire_cnt_reg, fire_cnt_next;
    logic                   pend_valid_reg, pend_valid_next;
    out_item_t              pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_item_reg;

    logic [63:0]            alu_a, alu_b, alu_sum;
    logic                   alu_sub, alu_carry;
    logic                   ram_we;
    logic [IDX_W-1:0]       rd_addr;
    slot_entry_t            ram_wdata, ram_rdata;
    logic [6:0]             slot_wide, idx_wide;
    logic                   in_range;
    logic [IDX_W-1:0]       wr_idx;
    logic                   at_last, hit, stall, out_free, push;
    out_item_t              push_item;

    assign slot_wide = 7'(s_item.slot);
    assign in_range  = slot_wide < 7'(NUM_SLOTS);
    assign wr_idx    = slot_wide[IDX_W-1:0];
    assign idx_wide  = 7'(idx_reg);
    assign at_last   = idx_reg == IDX_W'(NUM_SLOTS - 1);
    assign out_free  = !out_valid_reg || m_ready;

    assign ram_wdata = '{deadline: alu_sum, action_tag: s_item.action_tag,
                         ctx_tag: s_item.context_tag};

    ttb_add64 u_add (
        .op_a  (alu_a),
        .op_b  (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    ttb_slot_ram #(
        .DEPTH (NUM_SLOTS),
        .IDX_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_idx),
        .wr_data (ram_wdata),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // adder operand select per state
    always_comb begin
        alu_a   = now_reg;
        alu_b   = 64'd1;
        alu_sub = 1'b0;
        case (state_reg)
            S_IDLE: begin
                alu_b = {32'd0, s_item.delay_ms};
            end
            S_SCAN: begin
                alu_b   = ram_rdata.deadline;
                alu_sub = 1'b1;
            end
            default: begin
                alu_b = 64'd1;
            end
        endcase
    end

    assign hit   = (state_reg == S_SCAN) && armed_reg[idx_reg] && alu_carry
                   && (fire_cnt_reg != MAX_FIRE);
    assign stall = hit && pend_valid_reg && !out_free;

    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        armed_next      = armed_reg;
        idx_next        = idx_reg;
        fire_cnt_next   = fire_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        ram_we          = 1'b0;
        rd_addr         = '0;
        push            = 1'b0;
        push_item       = pend_reg;
        s_ready         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_item.op)
                        OP_TICK: begin
                            state_next    = S_TICK;
                            idx_next      = '0;
                            fire_cnt_next = '0;
                        end
                        OP_ARM: begin
                            if (in_range) begin
                                ram_we             = 1'b1;
                                armed_next[wr_idx] = 1'b1;
                            end
                        end
                        OP_CANCEL: begin
                            if (in_range) begin
                                armed_next[wr_idx] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                now_next   = alu_sum;
                rd_addr    = '0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                // prefetch the next slot unless at the last slot or held on a full output
                rd_addr = (stall || at_last) ? idx_reg : idx_reg + 1'b1;
                if (hit && !stall) begin
                    if (pend_valid_reg) begin
                        push           = 1'b1;
                        push_item      = pend_reg;
                        push_item.last = 1'b0;
                    end
                    pend_valid_next     = 1'b1;
                    pend_next           = '{fired_slot: idx_wide[3:0],
                                            fired_action: ram_rdata.action_tag,
                                            fired_context: ram_rdata.ctx_tag,
                                            last: 1'b0};
                    fire_cnt_next       = fire_cnt_reg + 5'd1;
                    armed_next[idx_reg] = 1'b0;
                end
                if (!stall) begin
                    if (at_last) begin
                        state_next = S_FLUSH;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    push_item       = pend_reg;
                    push_item.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (push) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            armed_reg      <= '0;
            idx_reg        <= '0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            armed_reg      <= armed_next;
            idx_reg        <= idx_next;
            fire_cnt_reg   <= fire_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        if (push) begin
            out_item_reg <= push_item;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    a_fire_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_cnt_reg <= MAX_FIRE)
        else $error("expiry count above limit");

    a_tick_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_TICK |=> now_reg == $past(now_reg) + 64'd1)
        else $error("time did not advance by one on tick");

    a_hit_disarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (hit && !stall) |=> !armed_reg[$past(idx_reg)])
        else $error("expired slot still armed");

    a_flush_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH && pend_valid_reg && out_free)
        |=> (state_reg == S_IDLE && !pend_valid_reg && m_valid && m_item.last))
        else $error("final result of tick not released");

endmodule

// File: tb/sv/ttb_expiry_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_expiry_checker
// Watches both channels of the timeout timer bank and checks its expiries.
// ----------------------------------------------------------------------------
// Keeps its own copy of the running time, the armed flags, deadlines and
// tags. Every accepted arm, cancel or tick item updates that copy; a tick
// queues the expiries it should cause in slot order. Every accepted result
// is checked field by field against the oldest queued expiry.
module ttb_expiry_checker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  ttb_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  ttb_pkg::out_item_t m_item,
    output int                 fail_count,
    output int                 expected_left,
    output int                 results_seen
);
    import ttb_pkg::*;

    logic [63:0] now_ms_q;
    logic        armed_q    [NUM_SLOTS];
    logic [63:0] deadline_q [NUM_SLOTS];
    logic [15:0] action_q   [NUM_SLOTS];
    logic [15:0] context_q  [NUM_SLOTS];

    out_item_t pending_expiries[$];
    int        mismatches = 0;
    int        checked = 0;

    task automatic predict_timer_item(input in_item_t it);
        int        fired;
        out_item_t r;
        fired = 0;
        case (it.op)
            OP_ARM: begin
                if (it.slot < NUM_SLOTS) begin
                    deadline_q[it.slot] = now_ms_q + {32'd0, it.delay_ms};
                    action_q[it.slot]   = it.action_tag;
                    context_q[it.slot]  = it.context_tag;
                    armed_q[it.slot]    = 1'b1;
                end
            end
            OP_CANCEL: begin
                if (it.slot < NUM_SLOTS) armed_q[it.slot] = 1'b0;
            end
            OP_TICK: begin
                now_ms_q = now_ms_q + 64'd1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (fired < MAX_FIRE && armed_q[i] && deadline_q[i] <= now_ms_q) begin
                        r.fired_slot    = i[3:0];
                        r.fired_action  = action_q[i];
                        r.fired_context = context_q[i];
                        r.last          = 1'b0;
                        pending_expiries.push_back(r);
                        armed_q[i] = 1'b0;
                        fired++;
                    end
                end
                // mark the final expiry of this tick
                if (fired > 0) pending_expiries[pending_expiries.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic int field_diff(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            now_ms_q = 64'd0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                armed_q[i]    = 1'b0;
                deadline_q[i] = 64'd0;
                action_q[i]   = 16'd0;
                context_q[i]  = 16'd0;
            end
            pending_expiries.delete();
        end else begin
            if (m_valid && m_ready) begin
                checked++;
                if (pending_expiries.size() == 0) begin
                    mismatches++;
                    $error("expiry result for slot %0d with none expected", m_item.fired_slot);
                end else begin
                    want = pending_expiries.pop_front();
                    mismatches += field_diff("fired_slot", want.fired_slot, m_item.fired_slot);
                    mismatches += field_diff("fired_action", want.fired_action,
                                             m_item.fired_action);
                    mismatches += field_diff("fired_context", want.fired_context,
                                             m_item.fired_context);
                    mismatches += field_diff("last", want.last, m_item.last);
                end
            end
            if (s_valid && s_ready) predict_timer_item(s_item);
        end
        fail_count    <= mismatches;
        expected_left <= pending_expiries.size();
        results_seen  <= checked;
    end

endmodule

// File: tb/sv/tb_timeout_timer_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timeout_timer_bank
// Stimulus and verdict for the timeout timer bank.
// ----------------------------------------------------------------------------
// A directed opening fills every slot for one full-bank tick, then covers
// re-arm, cancel of an idle slot, the unused op code, the largest delay and
// zero delay. A random part follows with mostly short delays so that slots
// keep expiring. The sender runs in bursts with gaps, the receiver stalls
// on its own changing pattern, and the checker beside the block compares.
module tb_timeout_timer_bank;
    import ttb_pkg::*;

    localparam int         NUM_SLOTS     = 16;
    localparam int         RANDOM_ITEMS  = 385;
    localparam int         DRAIN_LIMIT   = 4000;
    localparam int         SETTLE_CYCLES = 4 * NUM_SLOTS;
    localparam int         TIMEOUT_NS    = 8_000_000;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE,
        READY_SQUARE
    } ready_mode_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;

    int          fail_count;
    int          expected_left;
    int          results_seen;

    int          tick_count   = 0;
    int          arm_count    = 0;
    int          cancel_count = 0;
    int          unused_count = 0;
    logic        stuck        = 1'b0;

    ready_mode_t ready_mode   = READY_ALWAYS;
    int          stall_phase  = 0;

    timeout_timer_bank #(
        .NUM_SLOTS(NUM_SLOTS)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    ttb_expiry_checker #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .fail_count   (fail_count),
        .expected_left(expected_left),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: switch among always-ready, random, sparse and square-wave stall patterns
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 97 == 0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
        case (ready_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_RANDOM: m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_ready <= (stall_phase[2:0] == 3'd0);
            default:      m_ready <= stall_phase[3];
        endcase
    end

    function automatic in_item_t timer_item(logic [1:0] op, logic [3:0] slot,
                                            logic [31:0] delay, logic [15:0] act,
                                            logic [15:0] ctx);
        in_item_t it;
        it.op          = op;
        it.slot        = slot;
        it.delay_ms    = delay;
        it.action_tag  = act;
        it.context_tag = ctx;
        return it;
    endfunction

    // mostly short delays so armed slots come due within a few ticks
    function automatic in_item_t random_timer_item();
        int          pick;
        int          span;
        logic [31:0] delay;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 99);
        if (span < 70)      delay = $urandom_range(0, 6);
        else if (span < 90) delay = $urandom_range(7, 40);
        else if (span < 97) delay = $urandom();
        else                delay = 32'hFFFF_FFFF;
        if (pick < 40)
            return timer_item(OP_TICK, 4'($urandom()), $urandom(), 16'($urandom()),
                              16'($urandom()));
        if (pick < 78)
            return timer_item(OP_ARM, 4'($urandom()), delay, 16'($urandom()),
                              16'($urandom()));
        if (pick < 93)
            return timer_item(OP_CANCEL, 4'($urandom()), $urandom(), 16'($urandom()),
                              16'($urandom()));
        return timer_item(OP_UNUSED, 4'($urandom()), $urandom(), 16'($urandom()),
                          16'($urandom()));
    endfunction

    // hold valid high until the item is taken; call on a clock edge
    task automatic push_item(input in_item_t it);
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        case (it.op)
            OP_TICK:   tick_count++;
            OP_ARM:    arm_count++;
            OP_CANCEL: cancel_count++;
            default:   unused_count++;
        endcase
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain_expiries();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_left != 0) begin
            stuck = 1'b1;
            $error("%0d expiry results still outstanding", expected_left);
        end
    endtask

    initial begin
        in_item_t it;
        int       counted;
        int       burst_left;
        logic     mid_drain_done;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every slot due at once, tag extremes on the end slots
        for (int k = 0; k < NUM_SLOTS; k++) begin
            push_item(timer_item(OP_ARM, k[3:0], 32'd0,
                                 (k == 0) ? 16'h0000 : (k == NUM_SLOTS - 1) ? 16'hFFFF
                                                                : 16'($urandom()),
                                 (k == 0) ? 16'hFFFF : (k == NUM_SLOTS - 1) ? 16'h0000
                                                                : 16'($urandom())));
        end
        push_item(timer_item(OP_TICK, 4'd0, 32'd0, 16'd0, 16'd0));
        pause_sender(3);
        push_item(timer_item(OP_ARM, 4'd3, 32'hFFFF_FFFF, 16'h1234, 16'hABCD));
        // re-arm drops the far deadline
        push_item(timer_item(OP_ARM, 4'd3, 32'd1, 16'h5A5A, 16'hA5A5));
        push_item(timer_item(OP_CANCEL, 4'd7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        push_item(timer_item(OP_UNUSED, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        push_item(timer_item(OP_ARM, 4'd9, 32'd2, 16'hC0DE, 16'h0BAD));
        push_item(timer_item(OP_CANCEL, 4'd9, 32'd0, 16'd0, 16'd0));
        push_item(timer_item(OP_TICK, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        push_item(timer_item(OP_TICK, 4'd0, 32'd0, 16'd0, 16'd0));
        drain_expiries();

        counted        = 0;
        burst_left     = 0;
        mid_drain_done = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            if (!mid_drain_done && counted >= RANDOM_ITEMS / 2) begin
                drain_expiries();
                mid_drain_done = 1'b1;
            end
            if (burst_left == 0) begin
                if ($urandom_range(0, 4) == 0) begin
                    burst_left = 40;
                end else begin
                    pause_sender($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 20);
                end
            end
            it = random_timer_item();
            push_item(it);
            burst_left--;
            counted++;
        end

        drain_expiries();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d ticks, %0d arms, %0d cancels, %0d unused-op items",
                 tick_count, arm_count, cancel_count, unused_count);
        $display("checked %0d expiry results under changing sender and receiver stalls",
                 results_seen);
        if (fail_count == 0 && !stuck) begin
            $display("tb_timeout_timer_bank: done, clean");
        end else begin
            $display("tb_timeout_timer_bank: done, errors");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_timeout_timer_bank: done, errors");
        $finish;
    end

endmodule
